// File: src/fefs_pkg.sv
// ----------------------------------------------------------------------------
// fefs_pkg
// Shared constants, codes and controller/datapath bundles of the fire stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fefs_pkg;

  // grid geometry
  localparam int GRID_W  = 60;
  localparam int GRID_H  = 120;
  localparam int CELLS   = GRID_W * GRID_H;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int K_W     = $clog2(GRID_W + 3);
  localparam int CS_W    = K_W + 2;
  localparam int BOT_BASE = (GRID_H - 1) * GRID_W;

  // item codes
  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FUEL_BASE = 2'd0;
  localparam logic [1:0] REG_FUEL_TILT = 2'd1;
  localparam logic [1:0] REG_WIND_TILT = 2'd2;
  localparam logic [1:0] REG_SEED      = 2'd3;

  // noise generator
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic restart;
    logic clr_run;
    logic read_issue;
    logic read_take;
    logic wind_upd;
    logic flut;
    logic fuel_run;
    logic row_run;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic fuel_last;
    logic row_last;
    logic frame_last;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

// File: src/fefs_ram.sv
// ----------------------------------------------------------------------------
// fefs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fefs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/fefs_ctrl.sv
// ----------------------------------------------------------------------------
// fefs_ctrl
// Sequencer for clear, read and frame step passes of the fire stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fefs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_op,
  input  wire fefs_pkg::sts_t  sts,
  output fefs_pkg::cmd_t       cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLEAR  = 9'b000000010,
    ST_READ   = 9'b000000100,
    ST_RDATA  = 9'b000001000,
    ST_WIND   = 9'b000010000,
    ST_FLUT   = 9'b000100000,
    ST_FUEL   = 9'b001000000,
    ST_ROW    = 9'b010000000,
    ST_RESULT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          boot_nxt  = 1'b0;
          priority case (in_op)
            fefs_pkg::OP_STEP:    state_nxt = ST_WIND;
            fefs_pkg::OP_READ:    state_nxt = ST_READ;
            fefs_pkg::OP_RESTART: begin
              cmd.restart = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default:              state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts.clr_last) begin
          state_nxt = boot_r ? ST_IDLE : ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_nxt      = ST_RDATA;
      end
      ST_RDATA: begin
        cmd.read_take = 1'b1;
        state_nxt     = ST_RESULT;
      end
      ST_WIND: begin
        cmd.wind_upd = 1'b1;
        state_nxt    = ST_FLUT;
      end
      ST_FLUT: begin
        cmd.flut  = 1'b1;
        state_nxt = ST_FUEL;
      end
      ST_FUEL: begin
        cmd.fuel_run = 1'b1;
        if (sts.fuel_last) begin
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_run = 1'b1;
        if (sts.row_last && sts.frame_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register, reset starts with a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/fefs_dp.sv
// ----------------------------------------------------------------------------
// fefs_dp
// Datapath: registers, noise generator, wind easing, fuel and diffusion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fefs_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fefs_pkg::cmd_t    cmd,
  output fefs_pkg::sts_t         sts,
  input  wire logic [1:0]        in_op,
  input  wire logic signed [1:0] in_tilt_x,
  input  wire logic signed [1:0] in_tilt_y,
  input  wire logic [6:0]        in_cell_row,
  input  wire logic [5:0]        in_cell_col,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [5:0]             out_heat_level,
  output logic                   out_step_done
);

  localparam int AW  = fefs_pkg::ADDR_W;
  localparam int KW  = fefs_pkg::K_W;
  localparam int CW  = fefs_pkg::CS_W;
  localparam logic signed [CW-1:0] COL_MAX = CW'(fefs_pkg::GRID_W - 1);
  localparam logic signed [CW-1:0] ONE_S   = CW'(1);

  // configuration
  logic [5:0]  fuel_base_r;
  logic [4:0]  fuel_tilt_r;
  logic [2:0]  wind_tilt_r;
  logic [31:0] seed_r;

  // state and item registers
  logic [31:0]        noise_r;
  logic signed [11:0] wind_r;
  logic signed [4:0]  wint_r;
  logic [1:0]         op_r;
  logic signed [1:0]  tx_r, ty_r;
  logic [6:0]         row_r;
  logic [5:0]         col_r;
  logic [AW-1:0]      clr_addr_r;
  logic [KW-1:0]      k_r;
  logic [AW-1:0]      rbase_r;
  logic [5:0]         win0_r, win1_r;
  logic [5:0]         res_heat_r;
  logic               out_valid_r;
  logic [5:0]         out_heat_r;
  logic               out_done_r;

  logic [5:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [5:0]    wdata;

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_heat_level = out_heat_r;
  assign out_step_done  = out_done_r;

  // noise draw
  logic [31:0] draw;
  assign draw = noise_r * fefs_pkg::LCG_MUL + fefs_pkg::LCG_INC;

  // wind easing toward tilt target
  logic signed [4:0]  tprod;
  logic signed [12:0] tgt13;
  logic signed [11:0] tgt12;
  logic signed [13:0] diff;
  logic signed [19:0] m20;
  logic [19:0]        mag20;
  logic [11:0]        rnd;
  logic signed [12:0] delta;
  logic signed [13:0] wsum;
  logic signed [11:0] wind_nxt;
  always_comb begin
    tprod = tx_r * $signed({1'b0, wind_tilt_r});
    tgt13 = {tprod, 8'b0};
    if (tgt13 > 13'sd2047) begin
      tgt12 = 12'sd2047;
    end else if (tgt13 < -13'sd2048) begin
      tgt12 = -12'sd2048;
    end else begin
      tgt12 = tgt13[11:0];
    end
    diff  = 14'(tgt12) - 14'(wind_r);
    m20   = 20'(diff) * 20'sd56;
    mag20 = m20[19] ? 20'(-m20) : 20'(m20);
    rnd   = 12'((mag20 + 20'd128) >> 8);
    delta = m20[19] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    wsum  = 14'(wind_r) + 14'(delta);
    if (wsum > 14'sd2047) begin
      wind_nxt = 12'sd2047;
    end else if (wsum < -14'sd2048) begin
      wind_nxt = -12'sd2048;
    end else begin
      wind_nxt = wsum[11:0];
    end
  end

  // integer wind plus flutter
  logic signed [3:0] flutter;
  logic [11:0]       wmag;
  logic [3:0]        wr4;
  logic signed [5:0] wr_s;
  logic signed [4:0] wint_nxt;
  always_comb begin
    flutter  = $signed({2'b0, draw[31:30]}) - 4'sd1;
    wmag     = wind_r[11] ? 12'(-wind_r) : 12'(wind_r);
    wr4      = 4'((wmag + 12'd128) >> 8);
    wr_s     = wind_r[11] ? -$signed({2'b0, wr4}) : $signed({2'b0, wr4});
    wint_nxt = 5'(wr_s + 6'(flutter));
  end

  // bottom row fuel
  logic signed [7:0] fprod;
  logic signed [9:0] fheat;
  logic [5:0]        fuel_v;
  always_comb begin
    fprod = ty_r * $signed({1'b0, fuel_tilt_r});
    fheat = $signed({4'b0, fuel_base_r}) + $signed({4'b0, draw[31:26]}) + 10'(fprod);
    if (fheat < 10'sd0) begin
      fuel_v = 6'd0;
    end else if (fheat > 10'sd63) begin
      fuel_v = 6'd63;
    end else begin
      fuel_v = fheat[5:0];
    end
  end

  // diffusion: clamped source column and averaged cell
  logic signed [CW-1:0] col_s;
  logic [AW-1:0]        colc;
  logic [8:0]           sum9;
  logic [17:0]          prodq;
  logic signed [7:0]    mcell;
  logic [5:0]           cell_v;
  logic                 cell_en, shift_en;
  always_comb begin
    col_s = $signed({2'b0, k_r}) + CW'(wint_r) - ONE_S;
    if (col_s < 0) begin
      colc = '0;
    end else if (col_s > COL_MAX) begin
      colc = AW'(fefs_pkg::GRID_W - 1);
    end else begin
      colc = AW'(col_s);
    end
    sum9     = {3'b0, win0_r} + {3'b0, win1_r} + {3'b0, rdata};
    // divide by three via reciprocal, exact for sums below 256
    prodq    = 18'(sum9) * 18'd171;
    mcell    = $signed({2'b0, prodq[14:9]}) - $signed({5'b0, draw[29:27]});
    cell_v   = mcell[7] ? 6'd0 : mcell[5:0];
    cell_en  = (k_r >= KW'(3));
    shift_en = (k_r >= KW'(1));
  end

  // read address of a single cell
  logic [AW-1:0] cell_addr;
  logic          in_range;
  assign cell_addr = AW'(row_r) * AW'(fefs_pkg::GRID_W) + AW'(col_r);
  assign in_range  = (32'(row_r) < fefs_pkg::GRID_H) && (32'(col_r) < fefs_pkg::GRID_W);

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_r;
    wdata = 6'd0;
    if (cmd.clr_run) begin
      we = 1'b1;
    end else if (cmd.fuel_run) begin
      we    = 1'b1;
      waddr = AW'(fefs_pkg::BOT_BASE) + AW'(k_r);
      wdata = fuel_v;
    end else if (cmd.row_run && cell_en) begin
      we    = 1'b1;
      waddr = rbase_r - AW'(fefs_pkg::GRID_W) + AW'(k_r - KW'(3));
      wdata = cell_v;
    end
    raddr = cmd.read_issue ? cell_addr : rbase_r + colc;
  end

  fefs_ram #(.WIDTH(6), .DEPTH(fefs_pkg::CELLS)) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status
  always_comb begin
    sts.clr_last   = (clr_addr_r == AW'(fefs_pkg::CELLS - 1));
    sts.fuel_last  = (k_r == KW'(fefs_pkg::GRID_W - 1));
    sts.row_last   = (k_r == KW'(fefs_pkg::GRID_W + 2));
    sts.frame_last = (rbase_r == AW'(fefs_pkg::GRID_W));
    sts.slot_free  = !out_valid_r || !out_stall;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fuel_base_r <= 6'd48;
      fuel_tilt_r <= 5'd6;
      wind_tilt_r <= 3'd2;
      seed_r      <= 32'd1;
      noise_r     <= 32'd1;
      wind_r      <= '0;
      clr_addr_r  <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          fefs_pkg::REG_FUEL_BASE: fuel_base_r <= cfg_data[5:0];
          fefs_pkg::REG_FUEL_TILT: fuel_tilt_r <= cfg_data[4:0];
          fefs_pkg::REG_WIND_TILT: wind_tilt_r <= cfg_data[2:0];
          fefs_pkg::REG_SEED:      seed_r      <= cfg_data;
          default: ;
        endcase
      end
      // restart and clearing sweep
      if (cmd.restart) begin
        noise_r    <= seed_r;
        wind_r     <= '0;
        clr_addr_r <= '0;
      end
      if (cmd.clr_run) begin
        clr_addr_r <= sts.clr_last ? '0 : clr_addr_r + AW'(1);
      end
      if (cmd.wind_upd) begin
        wind_r <= wind_nxt;
      end
      // noise draws and column counter
      if (cmd.flut) begin
        noise_r <= draw;
        k_r     <= '0;
      end
      if (cmd.fuel_run) begin
        noise_r <= draw;
        k_r     <= sts.fuel_last ? '0 : k_r + KW'(1);
      end
      if (cmd.row_run) begin
        if (cell_en) begin
          noise_r <= draw;
        end
        k_r <= sts.row_last ? '0 : k_r + KW'(1);
      end
      // result beat
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_op;
      tx_r  <= in_tilt_x;
      ty_r  <= in_tilt_y;
      row_r <= in_cell_row;
      col_r <= in_cell_col;
    end
    if (cmd.flut) begin
      wint_r <= wint_nxt;
    end
    if (cmd.fuel_run && sts.fuel_last) begin
      rbase_r <= AW'(fefs_pkg::BOT_BASE);
    end
    if (cmd.row_run) begin
      if (shift_en) begin
        win0_r <= win1_r;
        win1_r <= rdata;
      end
      if (sts.row_last) begin
        rbase_r <= rbase_r - AW'(fefs_pkg::GRID_W);
      end
    end
    if (cmd.read_take) begin
      res_heat_r <= in_range ? rdata : 6'd0;
    end
    if (cmd.out_load) begin
      out_heat_r <= (op_r == fefs_pkg::OP_READ) ? res_heat_r : 6'd0;
      out_done_r <= (op_r == fefs_pkg::OP_STEP) || (op_r == fefs_pkg::OP_RESTART);
    end
  end

endmodule
`default_nettype wire

// File: src/fire_effect_frame_step.sv
// ----------------------------------------------------------------------------
// fire_effect_frame_step
// Fire heat grid stepper with wind, noise fuel and cell readback.
// ----------------------------------------------------------------------------
// Usage: items enter on the in_ channel (valid/stall), one result beat per
// item leaves on the out_ channel (valid/stall). Registers are to be written
// on the cfg_ channel (valid/ready, ready always high) only while the block
// is idle; the block itself does not enforce it. Op frame step: fuel writes
// one cell a cycle, then each row streams the row below through the grid
// RAM's single read port, one cell a cycle plus window fill. Op restart
// sweeps the RAM with zeros. One item is in work at a time; the next item
// is taken as soon as the previous result sits in the output register.
// Reset: a clearing pass runs first, in_stall stays high. A stalled result
// holds in the output register; the block finishes its current item and
// waits there until the beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fire_effect_frame_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic signed [1:0] in_tilt_x,
  input  wire logic signed [1:0] in_tilt_y,
  input  wire logic [6:0]        in_cell_row,
  input  wire logic [5:0]        in_cell_col,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [5:0]             out_heat_level,
  output logic                   out_step_done,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  fefs_pkg::cmd_t cmd;
  fefs_pkg::sts_t sts;

  // sequencer
  fefs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath and grid memory
  fefs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_tilt_x      (in_tilt_x),
    .in_tilt_y      (in_tilt_y),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_heat_level (out_heat_level),
    .out_step_done  (out_step_done)
  );

endmodule
`default_nettype wire
